[rtl/core/s5rp_pkg.sv]
// ---------------------------------------------------------------------------
// s5rp_pkg
// Shared types, protocol constants and encoders for the SOCKS5 request parser.
// ---------------------------------------------------------------------------
package s5rp_pkg;

	// Protocol byte values
	localparam logic [7:0] SOCKS_VERSION = 8'h05;
	localparam logic [7:0] CMD_CONNECT   = 8'h01;
	localparam logic [7:0] RSV_ZERO      = 8'h00;
	localparam logic [7:0] ATYPE_IPV4    = 8'h01;
	localparam logic [7:0] ATYPE_NAME    = 8'h03;
	localparam logic [7:0] ATYPE_IPV6    = 8'h04;
	localparam logic [7:0] IPV4_LEN      = 8'd4;
	localparam logic [7:0] IPV6_LEN      = 8'd16;

	// Parse phase, one-hot internally
	typedef enum logic [7:0] {
		PH_VERSION  = 8'b0000_0001,
		PH_COMMAND  = 8'b0000_0010,
		PH_RESERVED = 8'b0000_0100,
		PH_ATYPE    = 8'b0000_1000,
		PH_ADDRESS  = 8'b0001_0000,
		PH_PORT     = 8'b0010_0000,
		PH_DONE     = 8'b0100_0000,
		PH_ERROR    = 8'b1000_0000
	} phase_t;

	// Parse state codes as reported on parse_state
	localparam logic [2:0] PS_VERSION  = 3'd0;
	localparam logic [2:0] PS_COMMAND  = 3'd1;
	localparam logic [2:0] PS_RESERVED = 3'd2;
	localparam logic [2:0] PS_ATYPE    = 3'd3;
	localparam logic [2:0] PS_ADDRESS  = 3'd4;
	localparam logic [2:0] PS_PORT     = 3'd5;
	localparam logic [2:0] PS_DONE     = 3'd6;
	localparam logic [2:0] PS_ERROR    = 3'd7;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_VERSION  = 3'd1,
		ERR_COMMAND  = 3'd2,
		ERR_RESERVED = 3'd3,
		ERR_ATYPE    = 3'd4,
		ERR_NAME_LEN = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		KIND_IPV4 = 2'd0,
		KIND_NAME = 2'd1,
		KIND_IPV6 = 2'd2
	} kind_t;

	// Parser context carried from one transaction to the next
	typedef struct packed {
		phase_t     phase;
		err_t       fault;
		kind_t      kind;
		logic [7:0] bytes_left;
		logic [7:0] position;
		logic [7:0] total_len;
		logic [15:0] port;
		logic       port_half;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		phase:      PH_VERSION,
		fault:      ERR_NONE,
		kind:       KIND_IPV4,
		bytes_left: 8'd0,
		position:   8'd0,
		total_len:  8'd0,
		port:       16'd0,
		port_half:  1'b0
	};

	// One result transaction
	typedef struct packed {
		logic [2:0]  parse_state;
		logic [2:0]  error_code;
		logic        finished;
		logic [1:0]  address_kind;
		logic        addr_byte_valid;
		logic [7:0]  addr_byte;
		logic [7:0]  addr_position;
		logic        addr_last;
		logic [7:0]  addr_total;
		logic [15:0] dest_port;
		logic        port_valid;
	} res_t;

	function automatic logic [2:0] phase_code(input phase_t p);
		logic [2:0] c;
		case (p)
			PH_VERSION:  c = PS_VERSION;
			PH_COMMAND:  c = PS_COMMAND;
			PH_RESERVED: c = PS_RESERVED;
			PH_ATYPE:    c = PS_ATYPE;
			PH_ADDRESS:  c = PS_ADDRESS;
			PH_PORT:     c = PS_PORT;
			PH_DONE:     c = PS_DONE;
			PH_ERROR:    c = PS_ERROR;
			default:     c = PS_ERROR;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/s5rp_step.sv]
// ---------------------------------------------------------------------------
// s5rp_step
// Next-context and result logic for one request byte.
// ---------------------------------------------------------------------------
module s5rp_step
	import s5rp_pkg::*;
(
	input  ctx_t       cur,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output ctx_t       nxt,
	output res_t       res
);

	logic       av;
	logic [7:0] apos;
	logic       alast;

	always_comb begin
		nxt   = cur;
		av    = 1'b0;
		apos  = 8'd0;
		alast = 1'b0;
		if (restart) begin
			nxt = CTX_RESET;
		end else begin
			case (cur.phase)
				PH_VERSION: begin
					if (data_byte == SOCKS_VERSION) begin
						nxt.phase = PH_COMMAND;
					end else begin
						nxt.phase = PH_ERROR;
						nxt.fault = ERR_VERSION;
					end
				end
				PH_COMMAND: begin
					if (data_byte == CMD_CONNECT) begin
						nxt.phase = PH_RESERVED;
					end else begin
						nxt.phase = PH_ERROR;
						nxt.fault = ERR_COMMAND;
					end
				end
				PH_RESERVED: begin
					if (data_byte == RSV_ZERO) begin
						nxt.phase = PH_ATYPE;
					end else begin
						nxt.phase = PH_ERROR;
						nxt.fault = ERR_RESERVED;
					end
				end
				PH_ATYPE: begin
					nxt.position = 8'd0;
					nxt.phase    = PH_ADDRESS;
					case (data_byte)
						ATYPE_IPV4: begin
							nxt.kind       = KIND_IPV4;
							nxt.bytes_left = IPV4_LEN;
							nxt.total_len  = IPV4_LEN;
						end
						ATYPE_NAME: begin
							// length byte comes next
							nxt.kind       = KIND_NAME;
							nxt.bytes_left = 8'd0;
							nxt.total_len  = 8'd0;
						end
						ATYPE_IPV6: begin
							nxt.kind       = KIND_IPV6;
							nxt.bytes_left = IPV6_LEN;
							nxt.total_len  = IPV6_LEN;
						end
						default: begin
							// keep kind and counters, report the bad type
							nxt.position = cur.position;
							nxt.phase    = PH_ERROR;
							nxt.fault    = ERR_ATYPE;
						end
					endcase
				end
				PH_ADDRESS: begin
					if (cur.bytes_left == 8'd0) begin
						// domain length byte: consume, do not pass through
						if (data_byte == 8'd0) begin
							nxt.phase = PH_ERROR;
							nxt.fault = ERR_NAME_LEN;
						end else begin
							nxt.bytes_left = data_byte;
							nxt.total_len  = data_byte;
						end
					end else begin
						av             = 1'b1;
						apos           = cur.position;
						alast          = (cur.bytes_left == 8'd1);
						nxt.position   = cur.position + 8'd1;
						nxt.bytes_left = cur.bytes_left - 8'd1;
						if (cur.bytes_left == 8'd1) begin
							nxt.phase     = PH_PORT;
							nxt.port_half = 1'b0;
						end
					end
				end
				PH_PORT: begin
					if (!cur.port_half) begin
						nxt.port      = {data_byte, 8'd0};
						nxt.port_half = 1'b1;
					end else begin
						nxt.port  = {cur.port[15:8], data_byte};
						nxt.phase = PH_DONE;
					end
				end
				default: begin
					// done or error: hold until restart
				end
			endcase
		end
	end

	always_comb begin
		res.parse_state     = phase_code(nxt.phase);
		res.error_code      = nxt.fault;
		res.finished        = (nxt.phase == PH_DONE) || (nxt.phase == PH_ERROR);
		res.address_kind    = nxt.kind;
		res.addr_byte_valid = av;
		res.addr_byte       = av ? data_byte : 8'd0;
		res.addr_position   = apos;
		res.addr_last       = alast;
		res.addr_total      = nxt.total_len;
		res.dest_port       = (nxt.phase == PH_DONE) ? nxt.port : 16'd0;
		res.port_valid      = (nxt.phase == PH_DONE);
	end

endmodule

[rtl/core/s5rp_ctx.sv]
// ---------------------------------------------------------------------------
// s5rp_ctx
// Parser context register; loads the next context on each processed byte.
// ---------------------------------------------------------------------------
module s5rp_ctx
	import s5rp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  ctx_t nxt,
	output ctx_t cur
);

	ctx_t ctx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (load) begin
			ctx_q <= nxt;
		end
	end

	assign cur = ctx_q;

endmodule

[rtl/core/socks5_request_parser_top.sv]
// ---------------------------------------------------------------------------
// socks5_request_parser_top
// SOCKS5 request parser: one request byte in, one status transaction out.
// ---------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_ready  | data_byte, restart
//  output  | out_valid / out_ready| parse_state .. port_valid (11 fields)
//
//  One transaction per cycle sustained while out_ready stays high; a byte
//  goes to the input register, then its result to the result register, where it is offered.
//  The context register updates when a byte moves into the result register.
//  Reset returns the context to the version phase and empties both stages.
//  With out_ready low the result holds and one more byte waits in the
//  input register; in_ready drops only when both are full.
// ---------------------------------------------------------------------------
module socks5_request_parser_top
	import s5rp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  parse_state,
	output logic [2:0]  error_code,
	output logic        finished,
	output logic [1:0]  address_kind,
	output logic        addr_byte_valid,
	output logic [7:0]  addr_byte,
	output logic [7:0]  addr_position,
	output logic        addr_last,
	output logic [7:0]  addr_total,
	output logic [15:0] dest_port,
	output logic        port_valid
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       restart_s1;
	logic       out_valid_q;
	res_t       res_q;
	logic       adv;
	ctx_t       cur;
	ctx_t       nxt;
	res_t       res;

	// advance stage 1 into the result register
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	s5rp_ctx u_ctx (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.nxt    (nxt),
		.cur    (cur)
	);

	s5rp_step u_step (
		.cur       (cur),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.nxt       (nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign parse_state     = res_q.parse_state;
	assign error_code      = res_q.error_code;
	assign finished        = res_q.finished;
	assign address_kind    = res_q.address_kind;
	assign addr_byte_valid = res_q.addr_byte_valid;
	assign addr_byte       = res_q.addr_byte;
	assign addr_position   = res_q.addr_position;
	assign addr_last       = res_q.addr_last;
	assign addr_total      = res_q.addr_total;
	assign dest_port       = res_q.dest_port;
	assign port_valid      = res_q.port_valid;

endmodule

[verif/socks5_request_parser_checker.sv]
// ---------------------------------------------------------------------------
// socks5_request_parser_checker
// Watches both channels of the SOCKS5 request parser. Each byte that is taken
// goes through a cycle-free parser model, and the status it should produce is
// queued. Each status that leaves the block is compared, field by field,
// with the oldest one queued.
// ---------------------------------------------------------------------------
module socks5_request_parser_checker
	import s5rp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  parse_state,
	input  logic [2:0]  error_code,
	input  logic        finished,
	input  logic [1:0]  address_kind,
	input  logic        addr_byte_valid,
	input  logic [7:0]  addr_byte,
	input  logic [7:0]  addr_position,
	input  logic        addr_last,
	input  logic [7:0]  addr_total,
	input  logic [15:0] dest_port,
	input  logic        port_valid,
	input  logic        end_of_test,
	output int          fail_count,
	output int          pending
);

	localparam int PRINT_LIMIT = 60;

	// parser model state
	logic [2:0]  st_phase;
	err_t        st_fault;
	kind_t       st_kind;
	logic [7:0]  left_cnt;
	logic [7:0]  addr_idx;
	logic [7:0]  addr_len;
	logic [15:0] port_acc;
	logic        port_low_next;
	logic        end_checked;

	res_t status_q[$];

	task automatic report(input string msg);
		if (fail_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic restore_idle();
		st_phase = PS_VERSION;
		st_fault = ERR_NONE;
		st_kind = KIND_IPV4;
		left_cnt = 8'd0;
		addr_idx = 8'd0;
		addr_len = 8'd0;
		port_acc = 16'd0;
		port_low_next = 1'b0;
	endtask

	task automatic abort_request(input err_t code);
		st_fault = code;
		st_phase = PS_ERROR;
	endtask

	// Advance the parser by one byte and queue the status it reports.
	task automatic parse_request_byte(input logic [7:0] b, input logic rs);
		res_t r;
		r = '0;
		if (rs) begin
			restore_idle();
		end else begin
			case (st_phase)
				PS_VERSION: begin
					if (b == SOCKS_VERSION) st_phase = PS_COMMAND;
					else abort_request(ERR_VERSION);
				end
				PS_COMMAND: begin
					if (b == CMD_CONNECT) st_phase = PS_RESERVED;
					else abort_request(ERR_COMMAND);
				end
				PS_RESERVED: begin
					if (b == RSV_ZERO) st_phase = PS_ATYPE;
					else abort_request(ERR_RESERVED);
				end
				PS_ATYPE: begin
					if (b == ATYPE_IPV4) begin
						st_kind = KIND_IPV4;
						left_cnt = IPV4_LEN;
						addr_len = IPV4_LEN;
						addr_idx = 8'd0;
						st_phase = PS_ADDRESS;
					end else if (b == ATYPE_NAME) begin
						st_kind = KIND_NAME;
						left_cnt = 8'd0;
						addr_len = 8'd0;
						addr_idx = 8'd0;
						st_phase = PS_ADDRESS;
					end else if (b == ATYPE_IPV6) begin
						st_kind = KIND_IPV6;
						left_cnt = IPV6_LEN;
						addr_len = IPV6_LEN;
						addr_idx = 8'd0;
						st_phase = PS_ADDRESS;
					end else begin
						abort_request(ERR_ATYPE);
					end
				end
				PS_ADDRESS: begin
					if (left_cnt == 8'd0) begin
						// domain length byte: consume it, do not pass it on
						if (b == 8'd0) begin
							abort_request(ERR_NAME_LEN);
						end else begin
							left_cnt = b;
							addr_len = b;
						end
					end else begin
						r.addr_byte_valid = 1'b1;
						r.addr_byte = b;
						r.addr_position = addr_idx;
						r.addr_last = (left_cnt == 8'd1);
						addr_idx = addr_idx + 8'd1;
						left_cnt = left_cnt - 8'd1;
						if (left_cnt == 8'd0) begin
							st_phase = PS_PORT;
							port_low_next = 1'b0;
						end
					end
				end
				PS_PORT: begin
					if (!port_low_next) begin
						port_acc = {b, 8'h00};
						port_low_next = 1'b1;
					end else begin
						port_acc[7:0] = b;
						st_phase = PS_DONE;
					end
				end
				default: ;
			endcase
		end
		r.parse_state = st_phase;
		r.error_code = st_fault;
		r.finished = (st_phase == PS_DONE) || (st_phase == PS_ERROR);
		r.address_kind = st_kind;
		r.addr_total = addr_len;
		r.dest_port = (st_phase == PS_DONE) ? port_acc : 16'd0;
		r.port_valid = (st_phase == PS_DONE);
		status_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t seen, want;
		if (!arst_n) begin
			restore_idle();
			status_q.delete();
			fail_count = 0;
			end_checked = 1'b0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {parse_state, error_code, finished, address_kind, addr_byte_valid,
					addr_byte, addr_position, addr_last, addr_total, dest_port, port_valid};
				if (status_q.size() == 0) begin
					report("status transaction with none pending");
				end else begin
					want = status_q.pop_front();
					check_field("parse_state", 16'(seen.parse_state),
						16'(want.parse_state));
					check_field("error_code", 16'(seen.error_code),
						16'(want.error_code));
					check_field("finished", 16'(seen.finished), 16'(want.finished));
					check_field("address_kind", 16'(seen.address_kind),
						16'(want.address_kind));
					check_field("addr_byte_valid", 16'(seen.addr_byte_valid),
						16'(want.addr_byte_valid));
					check_field("addr_byte", 16'(seen.addr_byte), 16'(want.addr_byte));
					check_field("addr_position", 16'(seen.addr_position),
						16'(want.addr_position));
					check_field("addr_last", 16'(seen.addr_last), 16'(want.addr_last));
					check_field("addr_total", 16'(seen.addr_total),
						16'(want.addr_total));
					check_field("dest_port", seen.dest_port, want.dest_port);
					check_field("port_valid", 16'(seen.port_valid),
						16'(want.port_valid));
				end
			end
			if (in_valid && in_ready)
				parse_request_byte(data_byte, restart);
			if (end_of_test && !end_checked) begin
				if (status_q.size() != 0)
					report($sformatf("%0d status transactions never arrived",
						status_q.size()));
				end_checked = 1'b1;
			end
			pending <= status_q.size();
		end
	end

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Feeds the SOCKS5 request parser with request bytes: first each error path,
// then random requests, mostly well formed with random addresses and ports,
// some corrupted, cut short or pure noise. Both channels stall at random.
// The checker beside the block does the prediction and comparison.
// ---------------------------------------------------------------------------
module testbench;
	import s5rp_pkg::*;

	localparam int ITEM_TARGET    = 1550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam logic RST = 1'b1;
	localparam logic RUN = 1'b0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  parse_state;
	logic [2:0]  error_code;
	logic        finished;
	logic [1:0]  address_kind;
	logic        addr_byte_valid;
	logic [7:0]  addr_byte;
	logic [7:0]  addr_position;
	logic        addr_last;
	logic [7:0]  addr_total;
	logic [15:0] dest_port;
	logic        port_valid;
	logic        end_of_test = 1'b0;
	int          fail_count;
	int          pending;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int req_bytes = 0;
	int quiet_cycles = 0;

	socks5_request_parser_top dut (.*);
	socks5_request_parser_checker chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		req_bytes++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// One request, then up to two extra bytes and a restart.
	task automatic run_request();
		logic [7:0] req[$];
		logic [7:0] atype;
		logic [15:0] port;
		int unsigned n, k, cut;
		req = {SOCKS_VERSION, CMD_CONNECT, RSV_ZERO};
		k = $urandom_range(99);
		if (k < 40) atype = ATYPE_IPV4;
		else if (k < 75) atype = ATYPE_NAME;
		else atype = ATYPE_IPV6;
		req.push_back(atype);
		if (atype == ATYPE_IPV4) begin
			n = 32'(IPV4_LEN);
		end else if (atype == ATYPE_IPV6) begin
			n = 32'(IPV6_LEN);
		end else begin
			// longest names only now and then
			n = ($urandom_range(29) == 0) ? 255 : $urandom_range(1, 16);
			req.push_back(n[7:0]);
		end
		repeat (n) req.push_back(8'($urandom));
		case ($urandom_range(3))
			0: port = 16'h0000;
			1: port = 16'hFFFF;
			default: port = 16'($urandom);
		endcase
		req.push_back(port[15:8]);
		req.push_back(port[7:0]);
		k = $urandom_range(99);
		if (k < 12) begin
			// hit the header checks and the name length
			req[$urandom_range(4)] = $urandom_range(1) ? 8'h00 : 8'($urandom);
		end else if (k < 20) begin
			cut = $urandom_range(req.size() - 1);
			while (req.size() > cut) void'(req.pop_back());
		end else if (k < 25) begin
			req.delete();
			repeat ($urandom_range(1, 6)) req.push_back(8'($urandom));
		end
		foreach (req[i]) send_byte(req[i], RUN);
		repeat ($urandom_range(2)) send_byte(8'($urandom), RUN);
		send_byte(8'($urandom), RST);
	endtask

	initial begin
		logic [8:0] opening[$];
		opening = '{
			{RUN, 8'h04}, {RUN, 8'hFF}, {RST, 8'h00},
			{RUN, SOCKS_VERSION}, {RUN, 8'h02}, {RST, 8'hFF},
			{RUN, SOCKS_VERSION}, {RUN, CMD_CONNECT}, {RUN, 8'h80}, {RST, 8'h7F},
			{RUN, SOCKS_VERSION}, {RUN, CMD_CONNECT}, {RUN, RSV_ZERO}, {RUN, 8'h02},
			{RST, 8'hA5},
			{RUN, SOCKS_VERSION}, {RUN, CMD_CONNECT}, {RUN, RSV_ZERO}, {RUN, ATYPE_NAME},
			{RUN, 8'h00}, {RST, 8'h5A}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 18;
		recv_idle_pct <= 83;
		foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 83;
				recv_idle_pct <= 18;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			while (req_bytes < ITEM_TARGET * (ph + 1) / 3) run_request();
			// hold the sender until every status is back
			wait_drained();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
